// ===== rtl/assert_macros.svh =====
// Assertion macros used by the top RTL file of the LRU key-value cache.
// No dependencies; pulled in with an include ahead of the module that asserts.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge while reset is low.
`define ASSERT_CLK_RST(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every rising edge, reset included.
`define ASSERT_CLK(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/lkvc_pkg.sv =====
// Package of the LRU key-value cache: transaction payload types, sequencer
// control structs and shared constants. No dependencies.
package lkvc_pkg;

   localparam int DATA_W      = 32;
   localparam int CAP_W       = 5;
   localparam int ENTRIES_DEF = 16;

   localparam logic [CAP_W-1:0]  CAP_RESET  = 5'd16;
   localparam logic [DATA_W-1:0] MISS_VALUE = 32'hFFFF_FFFF;

   localparam logic MODE_GET = 1'b0;
   localparam logic MODE_PUT = 1'b1;

   typedef struct packed {
      logic                     mode;
      logic signed [DATA_W-1:0] key;
      logic signed [DATA_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic                     hit;
      logic signed [DATA_W-1:0] read_value;
      logic                     evicted;
      logic signed [DATA_W-1:0] evicted_key;
   } rsp_type;

   // Control from the sequencer to the scan unit.
   typedef struct packed {
      logic start;       // clear trackers for a new transaction
      logic sample;      // memory read data of one slot is valid
      logic slot_valid;  // valid bit of that slot
   } scan_ctl_type;

   // Write strobes from the sequencer to the store.
   typedef struct packed {
      logic key_we;
      logic val_we;
      logic val_re;
      logic rank_we;
   } store_ctl_type;

endpackage

// ===== rtl/lkvc_store.sv =====
// Key, value and age-rank memories of the LRU key-value cache.
// Depends on lkvc_pkg. One write and one registered read per memory per cycle.
module lkvc_store #(
   parameter int ENTRIES = lkvc_pkg::ENTRIES_DEF
) (
   input  logic                                         clock,
   input  lkvc_pkg::store_ctl_type                      ctl,
   input  logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] rd_addr,
   input  logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] val_rd_addr,
   input  logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] wr_addr,
   input  logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] rank_wr_addr,
   input  logic [lkvc_pkg::DATA_W-1:0]                  key_wr_data,
   input  logic [lkvc_pkg::DATA_W-1:0]                  val_wr_data,
   input  logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] rank_wr_data,
   output logic [lkvc_pkg::DATA_W-1:0]                  key_rd,
   output logic [lkvc_pkg::DATA_W-1:0]                  val_rd,
   output logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] rank_rd
);
   import lkvc_pkg::*;

   localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

   logic [DATA_W-1:0] key_mem  [ENTRIES];
   logic [DATA_W-1:0] val_mem  [ENTRIES];
   logic [IDX_W-1:0]  rank_mem [ENTRIES];

   always_ff @(posedge clock) begin
      if (ctl.key_we) begin
         key_mem[wr_addr] <= key_wr_data;
      end
      key_rd <= key_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (ctl.val_we) begin
         val_mem[wr_addr] <= val_wr_data;
      end
      if (ctl.val_re) begin
         val_rd <= val_mem[val_rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.rank_we) begin
         rank_mem[rank_wr_addr] <= rank_wr_data;
      end
      rank_rd <= rank_mem[rd_addr];
   end

endmodule

// ===== rtl/lkvc_scan.sv =====
// Scan unit of the LRU key-value cache: one key comparator and the trackers
// for the matching slot, the oldest valid slot and the first free slot.
// Depends on lkvc_pkg. Fed one slot per cycle by the sequencer.
module lkvc_scan #(
   parameter int ENTRIES = lkvc_pkg::ENTRIES_DEF
) (
   input  logic                                             clock,
   input  lkvc_pkg::scan_ctl_type                           ctl,
   input  logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] slot_idx,
   input  logic [lkvc_pkg::DATA_W-1:0]                      key_probe,
   input  logic [lkvc_pkg::DATA_W-1:0]                      mem_key,
   input  logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] mem_rank,
   output logic                                             found,
   output logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] found_idx,
   output logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] found_rank,
   output logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] lru_idx,
   output logic [lkvc_pkg::DATA_W-1:0]                      lru_key,
   output logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] free_idx
);
   import lkvc_pkg::*;

   localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

   logic             found_ff, found_in;
   logic             lru_have_ff, lru_have_in;
   logic             free_have_ff, free_have_in;
   logic [IDX_W-1:0] found_idx_ff, found_rank_ff;
   logic [IDX_W-1:0] lru_idx_ff, lru_rank_ff, free_idx_ff;
   logic [DATA_W-1:0] lru_key_ff;
   logic             match, lru_take, free_take;

   assign match     = ctl.sample && ctl.slot_valid && !found_ff && (mem_key == key_probe);
   assign lru_take  = ctl.sample && ctl.slot_valid &&
                      (!lru_have_ff || (mem_rank > lru_rank_ff));
   assign free_take = ctl.sample && !ctl.slot_valid && !free_have_ff;

   always_comb begin
      found_in     = found_ff || match;
      lru_have_in  = lru_have_ff || lru_take;
      free_have_in = free_have_ff || free_take;
      if (ctl.start) begin
         found_in     = 1'b0;
         lru_have_in  = 1'b0;
         free_have_in = 1'b0;
      end
   end

   // Flags are cleared by start before every use.
   always_ff @(posedge clock) begin
      found_ff     <= found_in;
      lru_have_ff  <= lru_have_in;
      free_have_ff <= free_have_in;
   end

   always_ff @(posedge clock) begin
      if (match) begin
         found_idx_ff  <= slot_idx;
         found_rank_ff <= mem_rank;
      end
      if (lru_take) begin
         lru_idx_ff  <= slot_idx;
         lru_rank_ff <= mem_rank;
         lru_key_ff  <= mem_key;
      end
      if (free_take) begin
         free_idx_ff <= slot_idx;
      end
   end

   assign found      = found_ff;
   assign found_idx  = found_idx_ff;
   assign found_rank = found_rank_ff;
   assign lru_idx    = lru_idx_ff;
   assign lru_key    = lru_key_ff;
   assign free_idx   = free_idx_ff;

endmodule

// ===== rtl/lru_key_value_cache.sv =====
// LRU key-value cache: fully associative store of ENTRIES key/value pairs with
// least-recently-used replacement. Each request transaction is a get or a put
// and yields exactly one response transaction. Keys, values and age ranks sit
// in memories with one write and one registered read port that one sequencer
// sweeps a slot per cycle: a scan pass through the single key comparator finds
// the hit, the oldest entry and the first free slot, then a rank pass ages the
// younger entries (all valid entries on an insert). A sweep reads all ENTRIES
// slots through the registered read port. A get miss takes the scan sweep only
// and every other request the scan and rank sweeps before its response is
// valid; a previous response still held under rsp_stall adds its wait.
// req_stall stays high from accept until the response is loaded into the
// output register, so a new request can enter while the previous response
// still waits under rsp_stall. Writing the capacity register clears the store
// at once; it must only be written while no request is in flight.
// Depends on lkvc_pkg, lkvc_store, lkvc_scan and assert_macros.svh.
`include "assert_macros.svh"

module lru_key_value_cache #(
   parameter int ENTRIES = lkvc_pkg::ENTRIES_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   // request channel
   input  logic                          req_valid,
   output logic                          req_stall,
   input  lkvc_pkg::req_type             req_payload,
   // response channel
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output lkvc_pkg::rsp_type             rsp_payload,
   // capacity register write
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [lkvc_pkg::CAP_W-1:0]    csr_capacity
);
   import lkvc_pkg::*;

   localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W = $clog2(ENTRIES + 1);
   localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

   localparam logic [CNT_W-1:0] CNT_END = CNT_W'(ENTRIES);
   localparam logic [CMP_W-1:0] CMP_ENT = CMP_W'(ENTRIES);
   localparam logic [CMP_W-1:0] CMP_ONE = CMP_W'(1);

   // sequencer states
   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_SCAN   = 3'd1;
   localparam logic [2:0] ST_DECIDE = 3'd2;
   localparam logic [2:0] ST_UPDATE = 3'd3;
   localparam logic [2:0] ST_DONE   = 3'd4;

   // control state
   logic [2:0]         state_ff, state_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               samp_vld_ff, samp_vld_in;
   logic [ENTRIES-1:0] valid_ff, valid_in;
   logic [CNT_W-1:0]   occ_ff, occ_in;
   logic [CAP_W-1:0]   cap_ff, cap_in;
   logic               rsp_valid_ff, rsp_valid_in;

   // payload state
   logic [IDX_W-1:0]  samp_idx_ff;
   req_type           req_ff;
   rsp_type           rsp_ff, rsp_in;
   logic              hit_ff, evict_ff, upd_all_ff;
   logic [IDX_W-1:0]  target_ff, thr_ff;
   logic [DATA_W-1:0] evkey_ff;

   // scan and store wiring
   scan_ctl_type      scan_ctl;
   store_ctl_type     store_ctl;
   logic              found;
   logic [IDX_W-1:0]  found_idx, found_rank, lru_idx, free_idx;
   logic [DATA_W-1:0] lru_key, key_rd, val_rd;
   logic [IDX_W-1:0]  rank_rd, rank_wr_data;

   logic              req_take, csr_take, rsp_free, issue, is_put;
   logic              need_evict, do_insert, older;
   logic [IDX_W-1:0]  target;
   logic [CMP_W-1:0]  cap_x, eff_cap, occ_x;

   assign req_stall = (state_ff != ST_IDLE);
   assign csr_ready = (state_ff == ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign csr_take  = csr_valid && csr_ready;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // effective capacity: zero acts as one, anything above ENTRIES as ENTRIES
   assign cap_x   = CMP_W'(cap_ff);
   assign occ_x   = CMP_W'(occ_ff);
   assign eff_cap = (cap_x == '0) ? CMP_ONE : ((cap_x > CMP_ENT) ? CMP_ENT : cap_x);

   // one slot read per cycle during both sweeps
   assign issue = ((state_ff == ST_SCAN) || (state_ff == ST_UPDATE)) && (cnt_ff < CNT_END);

   assign is_put     = (req_ff.mode == MODE_PUT);
   assign need_evict = !found && is_put && (occ_x >= eff_cap);
   assign do_insert  = !found && is_put;
   assign target     = found ? found_idx : (need_evict ? lru_idx : free_idx);

   assign scan_ctl.start      = req_take;
   assign scan_ctl.sample     = (state_ff == ST_SCAN) && samp_vld_ff;
   assign scan_ctl.slot_valid = valid_ff[samp_idx_ff];

   // rank pass: the target becomes rank 0, younger valid entries age by one
   // (all valid entries on an insert)
   assign older = valid_ff[samp_idx_ff] && (upd_all_ff || (rank_rd < thr_ff));

   always_comb begin
      store_ctl.key_we  = (state_ff == ST_DECIDE) && do_insert;
      store_ctl.val_we  = (state_ff == ST_DECIDE) && is_put;
      store_ctl.val_re  = (state_ff == ST_DECIDE) && found && !is_put;
      store_ctl.rank_we = (state_ff == ST_UPDATE) && samp_vld_ff &&
                          ((samp_idx_ff == target_ff) || older);
      rank_wr_data = (samp_idx_ff == target_ff) ? '0 : IDX_W'(rank_rd + 1'b1);
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = issue ? (cnt_ff + 1'b1) : cnt_ff;
      samp_vld_in  = issue;
      valid_in     = valid_ff;
      occ_in       = occ_ff;
      cap_in       = cap_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               state_in = ST_SCAN;
               cnt_in   = '0;
            end
         end
         ST_SCAN: begin
            // last sample lands at the edge that leaves this state
            if (!issue) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            cnt_in = '0;
            if (do_insert) begin
               valid_in[target] = 1'b1;
               if (!need_evict) begin
                  occ_in = occ_ff + 1'b1;
               end
            end
            state_in = (found || is_put) ? ST_UPDATE : ST_DONE;
         end
         ST_UPDATE: begin
            if (!issue) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in       = 1'b1;
               rsp_in.hit         = hit_ff;
               rsp_in.read_value  = (hit_ff && !is_put) ? val_rd : MISS_VALUE;
               rsp_in.evicted     = evict_ff;
               rsp_in.evicted_key = evict_ff ? evkey_ff : '0;
               state_in           = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // capacity write empties the store
      if (csr_take) begin
         cap_in   = csr_capacity;
         valid_in = '0;
         occ_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         samp_vld_ff  <= 1'b0;
         valid_ff     <= '0;
         occ_ff       <= '0;
         cap_ff       <= CAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         samp_vld_ff  <= samp_vld_in;
         valid_ff     <= valid_in;
         occ_ff       <= occ_in;
         cap_ff       <= cap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      samp_idx_ff <= cnt_ff[IDX_W-1:0];
      rsp_ff      <= rsp_in;
      if (req_take) begin
         req_ff <= req_payload;
      end
      if (state_ff == ST_DECIDE) begin
         hit_ff     <= found;
         evict_ff   <= need_evict;
         evkey_ff   <= lru_key;
         target_ff  <= target;
         upd_all_ff <= !found;
         thr_ff     <= found_rank;
      end
   end

   lkvc_scan #(
      .ENTRIES (ENTRIES)
   ) u_scan (
      .clock      (clock),
      .ctl        (scan_ctl),
      .slot_idx   (samp_idx_ff),
      .key_probe  (req_ff.key),
      .mem_key    (key_rd),
      .mem_rank   (rank_rd),
      .found      (found),
      .found_idx  (found_idx),
      .found_rank (found_rank),
      .lru_idx    (lru_idx),
      .lru_key    (lru_key),
      .free_idx   (free_idx)
   );

   lkvc_store #(
      .ENTRIES (ENTRIES)
   ) u_store (
      .clock        (clock),
      .ctl          (store_ctl),
      .rd_addr      (cnt_ff[IDX_W-1:0]),
      .val_rd_addr  (found_idx),
      .wr_addr      (target),
      .rank_wr_addr (samp_idx_ff),
      .key_wr_data  (req_ff.key),
      .val_wr_data  (req_ff.value),
      .rank_wr_data (rank_wr_data),
      .key_rd       (key_rd),
      .val_rd       (val_rd),
      .rank_rd      (rank_rd)
   );

   // occupancy tracks the valid bits and never passes the effective capacity
   `ASSERT_CLK_RST(a_occ_count, clock, reset, ($countones(valid_ff) == occ_ff), "occupancy does not match valid bits")
   `ASSERT_CLK_RST(a_occ_cap, clock, reset, (occ_x <= eff_cap), "occupancy above capacity")
   // a response is only produced from the final sequencer state
   `ASSERT_CLK_RST(a_rsp_src, clock, reset, ($rose(rsp_valid_ff) |-> ($past(state_ff) == ST_DONE)), "response without completed transaction")
   // an eviction only happens on a put that missed
   `ASSERT_CLK_RST(a_evict_miss, clock, reset, ((rsp_valid_ff && rsp_ff.evicted) |-> !rsp_ff.hit), "eviction reported on a hit")

endmodule

// ===== bench/tb_lru_key_value_cache.sv =====
// Self-checking testbench for lru_key_value_cache: directed table, then random
// get/put traffic over several capacity settings, with random stalls on both sides.
// Depends on lkvc_pkg and the lru_key_value_cache RTL.
module tb_lru_key_value_cache;
   import lkvc_pkg::*;

   localparam int SLOTS        = ENTRIES_DEF;
   localparam int RAND_ITEMS   = 1500;
   localparam int PHASES       = 10;
   localparam int POOL_MAX     = 24;
   // covers the slowest request, which makes two slot sweeps
   localparam int DRAIN_CYCLES = 2*SLOTS + 8;
   localparam int DRAIN_LIMIT  = 100000;
   localparam int RUN_LIMIT    = 2_000_000;
   localparam int REPORT_MAX   = 10;

   typedef enum bit {ROW_REQ, ROW_CFG} row_kind_type;

   // one line of the directed table; rsp is only used when typed is set
   typedef struct packed {
      row_kind_type      kind;
      logic [CAP_W-1:0]  cap;
      req_type           req;
      bit                typed;
      rsp_type           rsp;
   } script_row_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   req_type          req_payload = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   rsp_type          rsp_payload;
   logic             csr_valid = 1'b0;
   logic             csr_ready;
   logic [CAP_W-1:0] csr_capacity = '0;

   always #1 clock = ~clock;

   lru_key_value_cache #(.ENTRIES(SLOTS)) DUT (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_payload  (req_payload),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_payload  (rsp_payload),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_capacity (csr_capacity)
   );

   // ------------------------------------------------------------------
   // Shadow copy of the cache: slot contents, age ranks (0 = most recent),
   // occupancy and the raw capacity register.
   // ------------------------------------------------------------------
   logic [DATA_W-1:0] shadow_key  [SLOTS];
   logic [DATA_W-1:0] shadow_val  [SLOTS];
   bit                shadow_live [SLOTS];
   int unsigned       shadow_rank [SLOTS];
   int unsigned       shadow_count;
   logic [CAP_W-1:0]  shadow_cap;

   rsp_type        expected_rsp_q[$];
   script_row_type script_q[$];

   int unsigned mismatch_count = 0;
   int unsigned rsp_count = 0;
   int unsigned n_gets = 0, n_puts = 0, n_hits = 0, n_evicts = 0, n_cap_writes = 0;
   bit          no_idle = 1'b0;
   int unsigned stall_left = 0;

   function automatic void shadow_clear();
      int i;
      for (i = 0; i < SLOTS; i++) begin
         shadow_live[i] = 1'b0;
         shadow_rank[i] = 0;
      end
      shadow_count = 0;
   endfunction

   // register 0 behaves as 1, anything above the slot count as the slot count
   function automatic int unsigned usable_capacity();
      int unsigned c;
      c = shadow_cap;
      if (c < 1)
         c = 1;
      if (c > SLOTS)
         c = SLOTS;
      return c;
   endfunction

   // Apply one transaction to the shadow cache and return its response.
   function automatic rsp_type cache_access(req_type r);
      int          found;
      int          slot;
      int          i;
      int unsigned oldest;
      rsp_type     o;
      o.hit         = 1'b0;
      o.read_value  = MISS_VALUE;
      o.evicted     = 1'b0;
      o.evicted_key = '0;
      found = -1;
      for (i = 0; i < SLOTS; i++)
         if (found < 0 && shadow_live[i] && shadow_key[i] == r.key)
            found = i;
      if (found >= 0) begin
         o.hit = 1'b1;
         if (r.mode == MODE_PUT)
            shadow_val[found] = r.value;
         else
            o.read_value = shadow_val[found];
         // entries younger than the touched one age by one
         for (i = 0; i < SLOTS; i++)
            if (shadow_live[i] && shadow_rank[i] < shadow_rank[found])
               shadow_rank[i]++;
         shadow_rank[found] = 0;
      end else if (r.mode == MODE_PUT) begin
         slot = -1;
         if (shadow_count >= usable_capacity()) begin
            oldest = 0;
            for (i = 0; i < SLOTS; i++)
               if (shadow_live[i] && (slot < 0 || shadow_rank[i] > oldest)) begin
                  slot   = i;
                  oldest = shadow_rank[i];
               end
            if (slot >= 0) begin
               o.evicted      = 1'b1;
               o.evicted_key  = shadow_key[slot];
               shadow_live[slot] = 1'b0;
               shadow_count--;
            end
         end
         // no eviction: lowest free slot
         if (slot < 0)
            for (i = 0; i < SLOTS; i++)
               if (slot < 0 && !shadow_live[i])
                  slot = i;
         if (slot >= 0) begin
            for (i = 0; i < SLOTS; i++)
               if (shadow_live[i])
                  shadow_rank[i]++;
            shadow_key[slot]  = r.key;
            shadow_val[slot]  = r.value;
            shadow_live[slot] = 1'b1;
            shadow_rank[slot] = 0;
            shadow_count++;
         end
      end
      return o;
   endfunction

   // Idle length: mostly short, a few long; zero during no-idle stretches.
   function automatic int unsigned idle_len();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (no_idle || pick < 50)
         return 0;
      else if (pick < 90)
         return $urandom_range(1, 3);
      else if (pick < 98)
         return $urandom_range(4, 10);
      else
         return $urandom_range(20, 40);
   endfunction

   // ------------------------------------------------------------------
   // Directed table
   // ------------------------------------------------------------------
   function automatic void add_cfg(logic [CAP_W-1:0] cap);
      script_row_type row;
      row      = '0;
      row.kind = ROW_CFG;
      row.cap  = cap;
      script_q.push_back(row);
   endfunction

   // row checked against the shadow cache only
   function automatic void add_req(logic mode, logic [DATA_W-1:0] key,
                                   logic [DATA_W-1:0] value);
      script_row_type row;
      row           = '0;
      row.kind      = ROW_REQ;
      row.req.mode  = mode;
      row.req.key   = key;
      row.req.value = value;
      script_q.push_back(row);
   endfunction

   // row with the response written out by hand
   function automatic void add_typed(logic mode, logic [DATA_W-1:0] key,
                                     logic [DATA_W-1:0] value, logic hit,
                                     logic [DATA_W-1:0] rd, logic ev,
                                     logic [DATA_W-1:0] evk);
      script_row_type row;
      row                 = '0;
      row.kind            = ROW_REQ;
      row.req.mode        = mode;
      row.req.key         = key;
      row.req.value       = value;
      row.typed           = 1'b1;
      row.rsp.hit         = hit;
      row.rsp.read_value  = rd;
      row.rsp.evicted     = ev;
      row.rsp.evicted_key = evk;
      script_q.push_back(row);
   endfunction

   function automatic void build_script();
      // empty store after reset: every get misses
      add_typed(MODE_GET, 32'h0000_0000, 32'h0,         1'b0, MISS_VALUE, 1'b0, 32'h0);
      add_typed(MODE_GET, 32'h7FFF_FFFF, 32'h0,         1'b0, MISS_VALUE, 1'b0, 32'h0);
      add_typed(MODE_GET, 32'h8000_0000, 32'h0,         1'b0, MISS_VALUE, 1'b0, 32'h0);
      // extreme keys and values
      add_typed(MODE_PUT, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, MISS_VALUE, 1'b0, 32'h0);
      add_typed(MODE_GET, 32'h8000_0000, 32'h0,         1'b1, 32'h7FFF_FFFF, 1'b0, 32'h0);
      add_typed(MODE_PUT, 32'hFFFF_FFFF, 32'h8000_0000, 1'b0, MISS_VALUE, 1'b0, 32'h0);
      add_typed(MODE_PUT, 32'h8000_0000, 32'h0000_0000, 1'b1, MISS_VALUE, 1'b0, 32'h0);
      add_typed(MODE_GET, 32'hFFFF_FFFF, 32'h0,         1'b1, 32'h8000_0000, 1'b0, 32'h0);
      add_typed(MODE_GET, 32'h8000_0000, 32'h0,         1'b1, 32'h0, 1'b0, 32'h0);
      // get ignores its value field
      add_typed(MODE_GET, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0, MISS_VALUE, 1'b0, 32'h0);
      // capacity register of zero behaves as one; the write also clears
      add_cfg(5'd0);
      add_typed(MODE_GET, 32'h8000_0000, 32'h0,         1'b0, MISS_VALUE, 1'b0, 32'h0);
      add_typed(MODE_PUT, 32'h0000_0001, 32'd11,        1'b0, MISS_VALUE, 1'b0, 32'h0);
      add_typed(MODE_PUT, 32'h0000_0002, 32'd22,        1'b0, MISS_VALUE, 1'b1, 32'h1);
      add_typed(MODE_GET, 32'h0000_0001, 32'h0,         1'b0, MISS_VALUE, 1'b0, 32'h0);
      add_typed(MODE_GET, 32'h0000_0002, 32'h0,         1'b1, 32'd22, 1'b0, 32'h0);
      add_typed(MODE_PUT, 32'h0000_0002, 32'd33,        1'b1, MISS_VALUE, 1'b0, 32'h0);
      // capacity two: a get refreshes key 10, so key 20 is the victim
      add_cfg(5'd2);
      add_req(MODE_PUT, 32'd10, 32'd100);
      add_req(MODE_PUT, 32'd20, 32'd200);
      add_req(MODE_GET, 32'd10, 32'd0);
      add_req(MODE_PUT, 32'd30, 32'd300);
      add_req(MODE_GET, 32'd20, 32'd0);
      add_req(MODE_GET, 32'd30, 32'd0);
   endfunction

   function automatic logic [CAP_W-1:0] phase_capacity(int p);
      case (p)
         0:       return 5'd31;   // above the slot count
         1:       return 5'd0;    // acts as one
         2:       return 5'd1;
         3:       return 5'd16;
         4:       return 5'd2;
         5:       return 5'd17;
         default: return 5'($urandom_range(0, 31));
      endcase
   endfunction

   // ------------------------------------------------------------------
   // Request driver. Called at a rising edge; returns at the edge where the
   // transaction was accepted. Valid stays high across back-to-back items.
   // ------------------------------------------------------------------
   task automatic send_item(req_type r, bit typed, rsp_type typed_rsp);
      int unsigned gap;
      rsp_type     predicted;
      gap = idle_len();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= r;
      do
         @(posedge clock);
      while (req_stall);
      predicted = cache_access(r);
      expected_rsp_q.push_back(typed ? typed_rsp : predicted);
      if (r.mode == MODE_PUT)
         n_puts++;
      else
         n_gets++;
      if (predicted.hit)
         n_hits++;
      if (predicted.evicted)
         n_evicts++;
   endtask

   // Drop valid and let every outstanding response drain.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_rsp_q.size() != 0)
         @(posedge clock);
   endtask

   // Capacity write; only issued with nothing in flight.
   task automatic write_capacity(logic [CAP_W-1:0] cap);
      csr_valid    <= 1'b1;
      csr_capacity <= cap;
      do
         @(posedge clock);
      while (!csr_ready);
      csr_valid  <= 1'b0;
      shadow_cap  = cap;
      shadow_clear();
      n_cap_writes++;
   endtask

   // ------------------------------------------------------------------
   // Response side: random back-pressure, then compare every accepted
   // transaction against the oldest expectation.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else if (stall_left != 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= stall_left - 1;
      end else begin
         rsp_stall  <= 1'b0;
         stall_left <= idle_len();
      end
   end

   rsp_type want_rsp;

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         rsp_count++;
         if (expected_rsp_q.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_MAX)
               $display("unexpected response %0d: hit=%0b rd=%h ev=%0b evk=%h",
                        rsp_count, rsp_payload.hit, rsp_payload.read_value,
                        rsp_payload.evicted, rsp_payload.evicted_key);
         end else begin
            want_rsp = expected_rsp_q.pop_front();
            if (rsp_payload.hit !== want_rsp.hit ||
                rsp_payload.read_value !== want_rsp.read_value ||
                rsp_payload.evicted !== want_rsp.evicted ||
                rsp_payload.evicted_key !== want_rsp.evicted_key) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_MAX)
                  $display({"response %0d mismatch: expected hit=%0b rd=%h ev=%0b evk=%h",
                            " got hit=%0b rd=%h ev=%0b evk=%h"},
                           rsp_count, want_rsp.hit, want_rsp.read_value,
                           want_rsp.evicted, want_rsp.evicted_key,
                           rsp_payload.hit, rsp_payload.read_value,
                           rsp_payload.evicted, rsp_payload.evicted_key);
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------
   logic [DATA_W-1:0] key_pool [POOL_MAX];
   int unsigned       pool_size;
   int unsigned       drain_wait;
   req_type           rand_req;

   initial begin
      build_script();
      repeat (6) @(posedge clock);
      reset     <= 1'b0;
      shadow_cap = CAP_RESET;
      shadow_clear();
      @(posedge clock);

      // directed table
      foreach (script_q[n]) begin
         if (script_q[n].kind == ROW_CFG) begin
            wait_idle();
            write_capacity(script_q[n].cap);
         end else begin
            send_item(script_q[n].req, script_q[n].typed, script_q[n].rsp);
         end
      end

      // random phases: one capacity setting each, keys mostly from a pool a
      // little larger than the capacity so hits and evictions both happen
      for (int p = 0; p < PHASES; p++) begin
         wait_idle();
         write_capacity(phase_capacity(p));
         no_idle   = (p % 4 == 3);
         pool_size = usable_capacity() + $urandom_range(1, 4);
         for (int k = 0; k < POOL_MAX; k++)
            key_pool[k] = $urandom;
         case ($urandom_range(0, 3))
            0: key_pool[0] = 32'h0000_0000;
            1: key_pool[0] = 32'hFFFF_FFFF;
            2: key_pool[0] = 32'h8000_0000;
            default: key_pool[0] = 32'h7FFF_FFFF;
         endcase
         for (int k = 0; k < RAND_ITEMS / PHASES; k++) begin
            rand_req.mode  = 1'($urandom_range(0, 1));
            rand_req.key   = ($urandom_range(0, 99) < 88) ?
                             key_pool[$urandom_range(0, pool_size - 1)] : $urandom;
            rand_req.value = $urandom;
            send_item(rand_req, 1'b0, '0);
         end
      end
      no_idle = 1'b0;

      // drain, then watch a little longer for stray responses
      req_valid <= 1'b0;
      drain_wait = 0;
      while (expected_rsp_q.size() != 0 && drain_wait < DRAIN_LIMIT) begin
         @(posedge clock);
         drain_wait++;
      end
      if (expected_rsp_q.size() != 0) begin
         mismatch_count += expected_rsp_q.size();
         $display("%0d expected responses never arrived", expected_rsp_q.size());
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("ran %0d transactions (%0d gets, %0d puts) over %0d capacity settings",
               n_gets + n_puts, n_gets, n_puts, n_cap_writes);
      $display("saw %0d hits and %0d evictions; %0d mismatches",
               n_hits, n_evicts, mismatch_count);
      if (mismatch_count == 0)
         $display("[lru_key_value_cache] OK");
      else
         $display("[lru_key_value_cache] ERROR");
      $finish;
   end

   // watchdog
   initial begin
      #(RUN_LIMIT);
      $display("watchdog expired with %0d responses outstanding", expected_rsp_q.size());
      $display("[lru_key_value_cache] ERROR");
      $finish;
   end

endmodule
